@@ hdl/mfcr_pkg.sv @@
`default_nettype none

package mfcr_pkg;

   localparam int FRAME_DEPTH_DEFAULT = 65536;

   localparam logic [31:0] PAT_START     = 32'hFFAA_FFAA;
   localparam logic [31:0] PAT_CHUNK_BEG = 32'hFFCC_FFCC;
   localparam logic [31:0] PAT_CHUNK_END = 32'hFFDD_FFDD;

   localparam logic [24:0] IDX_MAX  = 25'h1FF_FFFF;
   localparam logic [15:0] FILL_MAX = 16'hFFFF;
   localparam logic [16:0] MS_MAX   = 17'h1_FFFF;

   localparam logic [15:0] CHUNK_LENGTH_RESET = 16'd240;
   localparam logic [15:0] TIMEOUT_MS_RESET   = 16'd5000;

   localparam logic MODE_TICK = 1'b1;

   localparam logic CSR_CHUNK_LENGTH = 1'b0;
   localparam logic CSR_TIMEOUT_MS   = 1'b1;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_SIZE = 2'd1,
      PHASE_DATA = 2'd2
   } phase_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic        write_en;
      logic [15:0] write_addr;
      logic [7:0]  write_data;
      logic        send_ack;
      logic        frame_done;
      logic [23:0] frame_length;
      logic        timed_out;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] chunk_length;
      logic [15:0] timeout_ms;
   } cfg_type;

endpackage

`default_nettype wire

@@ hdl/marker_framed_chunk_receiver_unit.sv @@
// Each accepted item passes from the input register to the result register; one item
// per cycle while results are taken. Chunk bookkeeping is a single compare-and-update.
// The input register and the result register each hold one item; while a result
// waits, one more item is taken and the input then stalls until the result goes.
// Synchronous active-high reset clears the handshake, the receiver state and
// sets chunk_length to 240 and timeout_ms to 5000.
`default_nettype none

module marker_framed_chunk_receiver_unit import mfcr_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_item_type      rsp_item,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   cfg_type      cfg_ff;
   rsp_item_type result;
   logic         out_free;
   logic         step;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   mfcr_engine #(
      .FRAME_DEPTH(FRAME_DEPTH)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_item_ff),
      .cfg   (cfg_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_item_ff <= result;
      end
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chunk_length <= CHUNK_LENGTH_RESET;
         cfg_ff.timeout_ms   <= TIMEOUT_MS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[2])
            CSR_CHUNK_LENGTH: cfg_ff.chunk_length <= csr_pwdata[15:0];
            CSR_TIMEOUT_MS:   cfg_ff.timeout_ms   <= csr_pwdata[15:0];
            default:          cfg_ff              <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_CHUNK_LENGTH: csr_prdata = {16'd0, cfg_ff.chunk_length};
         CSR_TIMEOUT_MS:   csr_prdata = {16'd0, cfg_ff.timeout_ms};
         default:          csr_prdata = 32'd0;
      endcase
   end

   done_with_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.frame_done |-> rsp_item.send_ack && !rsp_item.timed_out)
      else $error("frame done without acknowledge or with timeout");

   stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("input stalled with room in the pipeline");

   step_fills_output: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed item lost");

   reset_empties: assert property (@(posedge clock)
      reset |=> !out_valid_ff && !in_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

@@ hdl/mfcr_engine.sv @@
`default_nettype none

module mfcr_engine import mfcr_pkg::*; #(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_item_type item,
   input  wire cfg_type      cfg,
   output rsp_item_type      result
);

   localparam logic [25:0] DEPTH_LIMIT = 26'(FRAME_DEPTH);

   phase_type   phase_ff, phase_in;
   logic [31:0] window_ff, window_in;
   logic [1:0]  sizes_ff, sizes_in;
   logic [23:0] expected_ff, expected_in;
   logic [24:0] index_ff, index_in;
   logic [15:0] fill_ff, fill_in;
   logic [16:0] elapsed_ff, elapsed_in;

   logic        is_tick;
   logic        busy;
   logic [16:0] elapsed_inc;
   logic        tick_late;
   logic        chunk_late;
   logic [24:0] index_inc;
   logic [15:0] fill_inc;
   logic        is_start;
   logic        is_beg;
   logic        frame_end;
   logic        chunk_end;
   logic [23:0] size_lane;

   assign is_tick     = (item.mode == MODE_TICK);
   assign busy        = (phase_ff == PHASE_SIZE) || (phase_ff == PHASE_DATA);
   assign elapsed_inc = (elapsed_ff == MS_MAX) ? elapsed_ff : elapsed_ff + 17'd1;
   assign tick_late   = elapsed_inc > {1'b0, cfg.timeout_ms};
   assign chunk_late  = elapsed_ff > {1'b0, cfg.timeout_ms};
   assign index_inc   = (index_ff == IDX_MAX) ? index_ff : index_ff + 25'd1;
   assign fill_inc    = (fill_ff == FILL_MAX) ? fill_ff : fill_ff + 16'd1;
   assign window_in   = is_tick ? window_ff : {window_ff[23:0], item.rx_byte};
   assign is_start    = !is_tick && (window_in == PAT_START);
   assign is_beg      = !is_tick && (window_in == PAT_CHUNK_BEG);
   assign frame_end   = !is_tick && (window_in == PAT_CHUNK_END)
                        && (index_inc == {1'b0, expected_ff} + 25'd4);
   assign chunk_end   = !is_tick && (window_in == PAT_CHUNK_END) && !frame_end
                        && ({1'b0, fill_inc} == {1'b0, cfg.chunk_length} + 17'd4);

   always_comb begin
      case (sizes_ff)
         2'd0:    size_lane = {16'd0, item.rx_byte};
         2'd1:    size_lane = {8'd0, item.rx_byte, 8'd0};
         2'd2:    size_lane = {item.rx_byte, 16'd0};
         default: size_lane = 24'd0;
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PHASE_SIZE: begin
            if (is_tick) begin
               if (tick_late) phase_in = PHASE_IDLE;
            end else if (sizes_ff == 2'd2) begin
               phase_in = PHASE_DATA;
            end
         end
         PHASE_DATA: begin
            if (is_tick) begin
               if (tick_late) phase_in = PHASE_IDLE;
            end else if (!is_beg && (frame_end || (chunk_end && chunk_late))) begin
               phase_in = PHASE_IDLE;
            end
         end
         default: begin
            if (is_start) phase_in = PHASE_SIZE;
         end
      endcase
   end

   // counters and result
   always_comb begin
      sizes_in    = sizes_ff;
      expected_in = expected_ff;
      index_in    = index_ff;
      fill_in     = fill_ff;
      elapsed_in  = elapsed_ff;
      result      = '0;
      if (is_tick) begin
         if (busy) begin
            elapsed_in       = elapsed_inc;
            result.timed_out = tick_late;
         end
      end else begin
         case (phase_ff)
            PHASE_SIZE: begin
               expected_in = expected_ff | size_lane;
               sizes_in    = (sizes_ff == 2'd2) ? 2'd0 : sizes_ff + 2'd1;
            end
            PHASE_DATA: begin
               if (is_beg) begin
                  index_in = (fill_ff > index_ff) ? 25'd0 : index_ff - {9'd0, fill_ff};
                  fill_in  = 16'd0;
               end else begin
                  if ({1'b0, index_ff} < DEPTH_LIMIT) begin
                     result.write_en   = 1'b1;
                     result.write_addr = index_ff[15:0];
                     result.write_data = item.rx_byte;
                  end
                  index_in = index_inc;
                  fill_in  = fill_inc;
                  if (frame_end) begin
                     index_in          = index_inc - 25'd4;
                     result.send_ack   = 1'b1;
                     result.frame_done = 1'b1;
                  end else if (chunk_end) begin
                     index_in         = (index_inc >= 25'd4) ? index_inc - 25'd4 : 25'd0;
                     fill_in          = 16'd0;
                     result.send_ack  = 1'b1;
                     result.timed_out = chunk_late;
                  end
               end
            end
            default: begin
               if (is_start) begin
                  sizes_in    = 2'd0;
                  expected_in = 24'd0;
                  index_in    = 25'd0;
                  fill_in     = 16'd0;
                  elapsed_in  = 17'd0;
               end
            end
         endcase
      end
      result.frame_length = expected_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_IDLE;
         window_ff   <= '0;
         sizes_ff    <= '0;
         expected_ff <= '0;
         index_ff    <= '0;
         fill_ff     <= '0;
         elapsed_ff  <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         window_ff   <= window_in;
         sizes_ff    <= sizes_in;
         expected_ff <= expected_in;
         index_ff    <= index_in;
         fill_ff     <= fill_in;
         elapsed_ff  <= elapsed_in;
      end
   end

   size_count_range: assert property (@(posedge clock) disable iff (reset)
      sizes_ff != 2'd3)
      else $error("size byte count out of range");

   done_leaves_data: assert property (@(posedge clock) disable iff (reset)
      step && result.frame_done |=> phase_ff == PHASE_IDLE)
      else $error("frame end did not return to idle");

   idle_no_write: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PHASE_DATA |-> !result.write_en && !result.send_ack)
      else $error("write or acknowledge outside data phase");

endmodule

`default_nettype wire

@@ tb/marker_framed_chunk_receiver_unit_tb.sv @@
`timescale 1ns / 100ps

module marker_framed_chunk_receiver_unit_tb;
   import mfcr_pkg::*;

   localparam int          FRAME_DEPTH  = FRAME_DEPTH_DEFAULT;
   localparam logic        MODE_BYTE    = ~MODE_TICK;
   localparam int          RANDOM_ITEMS = 1300;
   localparam int          DRAIN_CYCLES = 4;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   marker_framed_chunk_receiver_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // receiver copy
   cfg_type     regs;
   phase_type   rx_phase;
   logic [31:0] byte_window;
   logic [1:0]  size_count;
   logic [23:0] announced_len;
   logic [24:0] mem_index;
   logic [15:0] fill_count;
   logic [16:0] ms_count;

   rsp_item_type frame_events_due[$];

   int          send_gap_max = 0;
   int          recv_gap_max = 0;
   int          rsp_hold_cycles = 0;
   int          tick_odds = 0;
   int          sent_items = 0;
   int          mismatch_count = 0;
   int unsigned cycle_count = 0;

   function automatic void clear_receiver();
      regs.chunk_length = CHUNK_LENGTH_RESET;
      regs.timeout_ms   = TIMEOUT_MS_RESET;
      rx_phase      = PHASE_IDLE;
      byte_window   = '0;
      size_count    = '0;
      announced_len = '0;
      mem_index     = '0;
      fill_count    = '0;
      ms_count      = '0;
   endfunction

   function automatic rsp_item_type receiver_step(input req_item_type item);
      rsp_item_type res;
      res = '0;
      if (item.mode == MODE_TICK) begin
         if (rx_phase == PHASE_SIZE || rx_phase == PHASE_DATA) begin
            if (ms_count != MS_MAX) ms_count = ms_count + 1'b1;
            if (ms_count > regs.timeout_ms) begin
               rx_phase = PHASE_IDLE;
               res.timed_out = 1'b1;
            end
         end
      end else begin
         byte_window = {byte_window[23:0], item.rx_byte};
         case (rx_phase)
            PHASE_SIZE: begin
               announced_len = announced_len | (24'(item.rx_byte) << (8 * size_count));
               size_count = size_count + 1'b1;
               if (size_count == 2'd3) begin
                  size_count = '0;
                  rx_phase = PHASE_DATA;
               end
            end
            PHASE_DATA: begin
               if (byte_window == PAT_CHUNK_BEG) begin
                  mem_index  = (fill_count > mem_index) ? '0 : mem_index - fill_count;
                  fill_count = '0;
               end else begin
                  if (mem_index < FRAME_DEPTH) begin
                     res.write_en   = 1'b1;
                     res.write_addr = mem_index[15:0];
                     res.write_data = item.rx_byte;
                  end
                  if (mem_index != IDX_MAX) mem_index = mem_index + 1'b1;
                  if (fill_count != FILL_MAX) fill_count = fill_count + 1'b1;
                  if (byte_window == PAT_CHUNK_END &&
                      32'(mem_index) == 32'(announced_len) + 32'd4) begin
                     mem_index = mem_index - 25'd4;
                     res.send_ack   = 1'b1;
                     res.frame_done = 1'b1;
                     rx_phase = PHASE_IDLE;
                  end else if (byte_window == PAT_CHUNK_END &&
                               32'(fill_count) == 32'(regs.chunk_length) + 32'd4) begin
                     mem_index = (mem_index >= 25'd4) ? mem_index - 25'd4 : '0;
                     res.send_ack = 1'b1;
                     fill_count = '0;
                     if (ms_count > regs.timeout_ms) begin
                        rx_phase = PHASE_IDLE;
                        res.timed_out = 1'b1;
                     end
                  end
               end
            end
            default: begin
               if (byte_window == PAT_START) begin
                  rx_phase      = PHASE_SIZE;
                  size_count    = '0;
                  announced_len = '0;
                  mem_index     = '0;
                  fill_count    = '0;
                  ms_count      = '0;
               end
            end
         endcase
      end
      res.frame_length = announced_len;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
   endtask

   task automatic check_field(input string field, input int got, input int want);
      if (got != want) report_mismatch(field, got, want);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_events_due.size() == 0) begin
            report_mismatch("result with nothing due", 32'(rsp_item.write_addr), 0);
         end else begin
            want = frame_events_due.pop_front();
            check_field("write_en", 32'(rsp_item.write_en), 32'(want.write_en));
            check_field("write_addr", 32'(rsp_item.write_addr), 32'(want.write_addr));
            check_field("write_data", 32'(rsp_item.write_data), 32'(want.write_data));
            check_field("send_ack", 32'(rsp_item.send_ack), 32'(want.send_ack));
            check_field("frame_done", 32'(rsp_item.frame_done), 32'(want.frame_done));
            check_field("frame_length", 32'(rsp_item.frame_length),
                        32'(want.frame_length));
            check_field("timed_out", 32'(rsp_item.timed_out), 32'(want.timed_out));
         end
      end
   end

   initial begin : result_sink
      int stall;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = $urandom_range(0, recv_gap_max);
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_item(input req_item_type item);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
      frame_events_due.push_back(receiver_step(item));
      @(negedge clock);
   endtask

   task automatic send_tick();
      req_item_type item;
      item.mode    = MODE_TICK;
      item.rx_byte = 8'($urandom_range(0, 255));
      send_item(item);
   endtask

   task automatic send_byte(input logic [7:0] value);
      req_item_type item;
      if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1) send_tick();
      item.mode    = MODE_BYTE;
      item.rx_byte = value;
      send_item(item);
   endtask

   task automatic send_marker(input logic [31:0] pattern);
      for (int i = 3; i >= 0; i--) send_byte(pattern[8*i +: 8]);
   endtask

   task automatic send_length(input logic [23:0] len, input int count);
      for (int i = 0; i < count; i++) send_byte(len[8*i +: 8]);
   endtask

   function automatic logic [7:0] frame_byte();
      case ($urandom_range(0, 15))
         0:       return 8'hFF;
         1:       return 8'hAA;
         2:       return 8'hCC;
         3:       return 8'hDD;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (frame_events_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic index, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {16'h0000, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (index)
         CSR_CHUNK_LENGTH: regs.chunk_length = value;
         CSR_TIMEOUT_MS:   regs.timeout_ms   = value;
         default:          ;
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[15:0] !== value)
         report_mismatch("register readback", csr_prdata, 32'(value));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] chunk_len, input logic [15:0] timeout);
      wait_drained();
      write_register(CSR_CHUNK_LENGTH, chunk_len);
      write_register(CSR_TIMEOUT_MS, timeout);
   endtask

   // tick out of a frame left open, where the timeout is short enough
   task automatic abandon_if_busy();
      while (rx_phase != PHASE_IDLE && regs.timeout_ms <= 300) send_tick();
   endtask

   task automatic test_directed_frame();
      tick_odds = 0;
      send_tick();
      send_byte(8'h00);
      send_marker(PAT_START);
      send_length(24'd2, 3);
      send_marker(PAT_START);
      send_tick();
      send_marker(PAT_CHUNK_BEG);
      send_byte(8'h5A);
      send_byte(8'hA5);
      send_marker(PAT_CHUNK_END);
      wait_drained();
   endtask

   task automatic test_chunk_acks();
      set_config(16'd1, 16'd65535);
      send_marker(PAT_START);
      send_length(24'd3, 3);
      send_byte(8'h11);
      send_marker(PAT_CHUNK_END);
      send_byte(8'h22);
      send_marker(PAT_CHUNK_BEG);
      send_byte(8'h22);
      send_marker(PAT_CHUNK_END);
      send_byte(8'h33);
      send_marker(PAT_CHUNK_END);
      wait_drained();
   endtask

   task automatic test_timeout();
      set_config(16'd1, 16'd0);
      send_marker(PAT_START);
      send_length(24'hFFFFFF, 3);
      send_tick();
      send_tick();
      set_config(16'd65531, 16'd3);
      send_marker(PAT_START);
      send_length(24'd1, 3);
      repeat (3) send_tick();
      send_byte(8'hFF);
      send_tick();
      wait_drained();
   endtask

   task automatic test_backpressure();
      set_config(16'd4, 16'd5000);
      send_gap_max = 0;
      recv_gap_max = 0;
      rsp_hold_cycles = 200;
      send_marker(PAT_START);
      send_length(24'd8, 3);
      repeat (2) begin
         repeat (4) send_byte(frame_byte());
         send_marker(PAT_CHUNK_END);
      end
      wait_drained();
   endtask

   task automatic send_random_frame();
      int          frame_len;
      int          remaining;
      int          n;
      int          short_chunk;
      logic [23:0] len_field;
      abandon_if_busy();
      repeat ($urandom_range(0, 3)) send_byte(frame_byte());
      send_marker(PAT_START);
      short_chunk = (regs.chunk_length > 12) ? 12 : regs.chunk_length;
      if (regs.timeout_ms <= 300 && $urandom_range(0, 7) == 0) begin
         len_field = 24'($urandom);
         send_length(len_field, $urandom_range(0, 3));
         repeat ($urandom_range(0, 2 * short_chunk + 4)) send_byte(frame_byte());
         return;
      end
      frame_len = $urandom_range(0, 4 * short_chunk + 3);
      send_length(24'(frame_len), 3);
      remaining = frame_len;
      do begin
         n = (remaining < regs.chunk_length) ? remaining : regs.chunk_length;
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(0, n)) send_byte(frame_byte());
            send_marker(PAT_CHUNK_BEG);
         end
         repeat (n) send_byte(frame_byte());
         send_marker(PAT_CHUNK_END);
         remaining -= n;
      end while (remaining > 0);
   endtask

   task automatic test_random_frames();
      int start_items;
      int frames;
      logic [15:0] chunk_len;
      logic [15:0] timeout;
      start_items = sent_items;
      frames = 0;
      while (sent_items - start_items < RANDOM_ITEMS) begin
         if (frames % 12 == 0) begin
            tick_odds = 0;
            abandon_if_busy();
            case ($urandom_range(0, 5))
               0:       chunk_len = 16'd1;
               1:       chunk_len = 16'd65531;
               default: chunk_len = 16'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 7))
               0:       timeout = 16'd0;
               1:       timeout = 16'd65535;
               2, 3:    timeout = 16'($urandom_range(1, 6));
               default: timeout = 16'($urandom_range(20, 200));
            endcase
            set_config(chunk_len, timeout);
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            tick_odds = 16;
         end
         send_random_frame();
         frames++;
      end
      tick_odds = 0;
      abandon_if_busy();
      wait_drained();
   endtask

   initial begin
      req_valid   = 1'b0;
      req_item    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      clear_receiver();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_gap_max = 6;
      recv_gap_max = 6;
      test_directed_frame();
      test_chunk_acks();
      test_timeout();
      test_backpressure();
      test_random_frames();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
